@@ hdl/tcva_pkg.sv @@
// Package for the trade CSV VWAP accumulator.
// Holds the record types, status codes and the decimal digit helper.
// No dependencies.
package tcva_pkg;

  localparam int TableEntriesDef   = 64;
  localparam int TickerCharsDef    = 8;
  localparam int PriceFracDigitsDef = 4;

  localparam int CodeW  = 64;
  localparam int AccW   = 32;
  localparam int TlenW  = 4;
  localparam int FcntW  = 3;
  localparam int ValW   = 64;
  localparam int VolW   = 48;
  localparam int SlotW  = 6;

  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  typedef enum logic [1:0] {
    StUpdated   = 2'd0,
    StMalformed = 2'd1,
    StFull      = 2'd2,
    StTooLong   = 2'd3
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [CodeW-1:0]  code;
    logic [AccW-1:0]   price;
    logic [FcntW-1:0]  fcnt;
    logic [AccW-1:0]   volume;
  } line_rec_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [CodeW-1:0]  code;
    logic [ValW-1:0]   value;
    logic [VolW-1:0]   volume;
  } res_rec_t;

  function automatic logic [AccW-1:0] dec_push(logic [AccW-1:0] acc, logic [3:0] digit);
    logic [AccW+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{AccW{1'b0}}, digit};
    dec_push = (v[AccW+3:AccW] != 4'b0) ? {AccW{1'b1}} : v[AccW-1:0];
  endfunction

endpackage

@@ hdl/tcva_fifo.sv @@
// Small synchronous queue of packed records.
// Used between front and back, and for results. No dependencies.
module tcva_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= din_i;
  end

endmodule

@@ hdl/tcva_front.sv @@
// Line parser: one byte a cycle while acc_i is high, a record per line end.
// Depends on tcva_pkg. Holds the skip-first-line register.
module tcva_front import tcva_pkg::*; #(
  parameter int TICKER_CHARS      = TickerCharsDef,
  parameter int PRICE_FRAC_DIGITS = PriceFracDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_skip_i,
  input  logic       acc_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       rec_push_o,
  output line_rec_t  rec_o
);
  logic             skip_q;
  logic [1:0]       fi_q, fi_d;
  logic [CodeW-1:0] tk_q, tk_d;
  logic [TlenW-1:0] tl_q, tl_d;
  logic [AccW-1:0]  pr_q, pr_d, vol_q, vol_d;
  logic             pdot_q, pdot_d, pdone_q, pdone_d;
  logic [FcntW-1:0] pcnt_q, pcnt_d;
  logic             first_q, first_d, nonempty_q, nonempty_d, voldone_q, voldone_d;
  logic             is_digit, fin;
  logic [3:0]       dig;
  logic [6:0]       shamt;

  assign is_digit = (data_byte_i >= CharZero) && (data_byte_i <= CharNine);
  assign dig      = data_byte_i[3:0];

  always_comb begin
    fi_d = fi_q; tk_d = tk_q; tl_d = tl_q; pr_d = pr_q; vol_d = vol_q;
    pdot_d = pdot_q; pdone_d = pdone_q; pcnt_d = pcnt_q;
    first_d = first_q; nonempty_d = nonempty_q; voldone_d = voldone_q;
    rec_push_o = 1'b0;
    rec_o = '0;
    fin = 1'b0;
    shamt = '0;
    if (acc_i) begin
      if (data_byte_i != CharNewline) begin
        nonempty_d = 1'b1;
        if (data_byte_i == CharComma && fi_q != 2'd3) begin
          fi_d = fi_q + 1'b1;
        end else begin
          case (fi_q)
            2'd1: begin
              if (tl_q < TlenW'(TICKER_CHARS)) begin
                tk_d = {tk_q[CodeW-9:0], data_byte_i};
                tl_d = tl_q + 1'b1;
              end else begin
                tl_d = TlenW'(TICKER_CHARS + 1);
              end
            end
            2'd2: begin
              if (!pdone_q) begin
                if (is_digit) begin
                  if (!pdot_q) begin
                    pr_d = dec_push(pr_q, dig);
                  end else if (pcnt_q < FcntW'(PRICE_FRAC_DIGITS)) begin
                    pr_d   = dec_push(pr_q, dig);
                    pcnt_d = pcnt_q + 1'b1;
                  end
                end else if (data_byte_i == CharDot && !pdot_q) begin
                  pdot_d = 1'b1;
                end else begin
                  pdone_d = 1'b1;
                end
              end
            end
            2'd3: begin
              if (!voldone_q) begin
                if (is_digit) vol_d = dec_push(vol_q, dig);
                else voldone_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      fin = (data_byte_i == CharNewline) || end_of_input_i;
      if (fin) begin
        rec_push_o = !(first_d && skip_q) && nonempty_d;
        shamt = {4'(4'd8 - tl_d), 3'b000};
        if (fi_d != 2'd3) begin
          rec_o.status = StMalformed;
        end else if (tl_d > TlenW'(TICKER_CHARS)) begin
          rec_o.status = StTooLong;
        end else begin
          rec_o.status = StUpdated;
          rec_o.code   = (tl_d == '0) ? '0 : (tk_d << shamt);
          rec_o.price  = pr_d;
          rec_o.fcnt   = pcnt_d;
          rec_o.volume = vol_d;
        end
        fi_d = '0; tk_d = '0; tl_d = '0; pr_d = '0; vol_d = '0;
        pdot_d = 1'b0; pdone_d = 1'b0; pcnt_d = '0;
        nonempty_d = 1'b0; voldone_d = 1'b0;
        first_d = end_of_input_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b1;
      fi_q <= '0; tk_q <= '0; tl_q <= '0; pr_q <= '0; vol_q <= '0;
      pdot_q <= 1'b0; pdone_q <= 1'b0; pcnt_q <= '0;
      first_q <= 1'b1; nonempty_q <= 1'b0; voldone_q <= 1'b0;
    end else begin
      if (cfg_we_i) skip_q <= cfg_skip_i;
      fi_q <= fi_d; tk_q <= tk_d; tl_q <= tl_d; pr_q <= pr_d; vol_q <= vol_d;
      pdot_q <= pdot_d; pdone_q <= pdone_d; pcnt_q <= pcnt_d;
      first_q <= first_d; nonempty_q <= nonempty_d; voldone_q <= voldone_d;
    end
  end

endmodule

@@ hdl/tcva_back.sv @@
// Table engine: scales price, searches and inserts the ticker, accumulates sums.
// Depends on tcva_pkg. Owns the key, value and volume memories.
module tcva_back import tcva_pkg::*; #(
  parameter int TABLE_ENTRIES     = TableEntriesDef,
  parameter int PRICE_FRAC_DIGITS = PriceFracDigitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_avail_i,
  input  line_rec_t rec_i,
  output logic      rec_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_rec_t  res_o
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    BIdle, BScale, BAddr, BCmp, BMul, BUpd
  } bstate_e;

  bstate_e          st_q;
  line_rec_t        cur_q;
  logic [KW-1:0]    k_q, used_q;
  logic [IW-1:0]    slot_q;
  logic             newent_q;
  logic [ValW-1:0]  prod_q;
  logic             res_push_q;
  res_rec_t         res_q;

  logic [CodeW-1:0] key_mem [TABLE_ENTRIES];
  logic [ValW-1:0]  val_mem [TABLE_ENTRIES];
  logic [VolW-1:0]  vol_mem [TABLE_ENTRIES];
  logic [CodeW-1:0] key_rd_q;
  logic [ValW-1:0]  val_rd_q;
  logic [VolW-1:0]  vol_rd_q;

  logic             key_we, sum_we, key_re, sum_re;
  logic [ValW:0]    val_sum;
  logic [VolW:0]    vol_sum;
  logic [ValW-1:0]  val_new;
  logic [VolW-1:0]  vol_new;

  assign rec_pop_o  = (st_q == BIdle) && rec_avail_i && !res_full_i && !res_push_q;
  assign res_push_o = res_push_q;
  assign res_o      = res_q;

  assign key_we = (st_q == BAddr) && (k_q == used_q) && (used_q != KW'(TABLE_ENTRIES));
  assign key_re = (st_q == BAddr) && (k_q != used_q);
  assign sum_re = (st_q == BMul);
  assign sum_we = (st_q == BUpd);

  assign val_sum = {1'b0, (newent_q ? '0 : val_rd_q)} + {1'b0, prod_q};
  assign vol_sum = {1'b0, (newent_q ? '0 : vol_rd_q)} + {{(VolW-AccW+1){1'b0}}, cur_q.volume};
  assign val_new = val_sum[ValW] ? '1 : val_sum[ValW-1:0];
  assign vol_new = vol_sum[VolW] ? '1 : vol_sum[VolW-1:0];

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[used_q[IW-1:0]] <= cur_q.code;
    if (key_re) key_rd_q <= key_mem[k_q[IW-1:0]];
    if (sum_re) begin
      val_rd_q <= val_mem[slot_q];
      vol_rd_q <= vol_mem[slot_q];
    end
    if (sum_we) begin
      val_mem[slot_q] <= val_new;
      vol_mem[slot_q] <= vol_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= BIdle;
      used_q     <= '0;
      res_push_q <= 1'b0;
    end else begin
      res_push_q <= 1'b0;
      unique case (st_q)
        BIdle: begin
          if (rec_pop_o) begin
            cur_q <= rec_i;
            if (rec_i.status != StUpdated) begin
              res_q      <= '{status: rec_i.status, default: '0};
              res_push_q <= 1'b1;
            end else begin
              st_q <= BScale;
            end
          end
        end
        BScale: begin
          if (cur_q.fcnt < FcntW'(PRICE_FRAC_DIGITS)) begin
            cur_q.price <= dec_push(cur_q.price, 4'd0);
            cur_q.fcnt  <= cur_q.fcnt + 1'b1;
          end else begin
            k_q  <= '0;
            st_q <= BAddr;
          end
        end
        BAddr: begin
          if (k_q == used_q) begin
            if (used_q == KW'(TABLE_ENTRIES)) begin
              res_q      <= '{status: StFull, code: cur_q.code, default: '0};
              res_push_q <= 1'b1;
              st_q       <= BIdle;
            end else begin
              slot_q   <= used_q[IW-1:0];
              newent_q <= 1'b1;
              used_q   <= used_q + 1'b1;
              st_q     <= BMul;
            end
          end else begin
            st_q <= BCmp;
          end
        end
        BCmp: begin
          if (key_rd_q == cur_q.code) begin
            slot_q   <= k_q[IW-1:0];
            newent_q <= 1'b0;
            st_q     <= BMul;
          end else begin
            k_q  <= k_q + 1'b1;
            st_q <= BAddr;
          end
        end
        BMul: begin
          prod_q <= cur_q.price * cur_q.volume;
          st_q   <= BUpd;
        end
        BUpd: begin
          res_q      <= '{status: StUpdated, slot: SlotW'(slot_q), code: cur_q.code,
                          value: val_new, volume: vol_new};
          res_push_q <= 1'b1;
          st_q       <= BIdle;
        end
        default: st_q <= BIdle;
      endcase
    end
  end

endmodule

@@ hdl/trade_csv_vwap_accumulator_unit.sv @@
// Channel   Handshake        Payload
// input     push_i / full_o  data_byte_i, end_of_input_i
// result    pop_i / empty_o  status_o, slot_o, ticker_code_o, total_value_o, total_volume_o
// config    skip_first_line_we_i  skip_first_line_i
// Bytes enter at one a cycle while full_o is low; a line end queues a record for the table
// engine unless the line is empty or the skipped first line. The engine pads the price,
// compares stored keys one by one via the key memory's single read port, inserts a new entry
// if none matches, then multiplies and updates the sums. Reset empties the table at once.
// full_o rises when the line queue fills; the engine stalls while the result queue is full.
// Depends on tcva_pkg, tcva_fifo, tcva_front, tcva_back.
module trade_csv_vwap_accumulator_unit import tcva_pkg::*; #(
  parameter int TABLE_ENTRIES     = TableEntriesDef,
  parameter int TICKER_CHARS      = TickerCharsDef,
  parameter int PRICE_FRAC_DIGITS = PriceFracDigitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             skip_first_line_we_i,
  input  logic             skip_first_line_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_input_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [1:0]       status_o,
  output logic [SlotW-1:0] slot_o,
  output logic [CodeW-1:0] ticker_code_o,
  output logic [ValW-1:0]  total_value_o,
  output logic [VolW-1:0]  total_volume_o
);
  logic      lq_full, lq_empty, lq_push, lq_pop, rq_full, rq_push;
  line_rec_t lq_din, lq_dout;
  res_rec_t  rq_din, rq_dout;

  assign full_o = lq_full;

  tcva_front #(.TICKER_CHARS(TICKER_CHARS), .PRICE_FRAC_DIGITS(PRICE_FRAC_DIGITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i(skip_first_line_we_i), .cfg_skip_i(skip_first_line_i),
    .acc_i(push_i && !lq_full), .data_byte_i, .end_of_input_i,
    .rec_push_o(lq_push), .rec_o(lq_din)
  );

  tcva_fifo #(.WIDTH($bits(line_rec_t)), .DEPTH(4)) u_lq (
    .clk_i, .rst_ni, .push_i(lq_push), .din_i(lq_din), .pop_i(lq_pop),
    .dout_o(lq_dout), .full_o(lq_full), .empty_o(lq_empty)
  );

  tcva_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .PRICE_FRAC_DIGITS(PRICE_FRAC_DIGITS)) u_back (
    .clk_i, .rst_ni, .rec_avail_i(!lq_empty), .rec_i(lq_dout), .rec_pop_o(lq_pop),
    .res_full_i(rq_full), .res_push_o(rq_push), .res_o(rq_din)
  );

  tcva_fifo #(.WIDTH($bits(res_rec_t)), .DEPTH(2)) u_rq (
    .clk_i, .rst_ni, .push_i(rq_push), .din_i(rq_din), .pop_i(pop_i),
    .dout_o(rq_dout), .full_o(rq_full), .empty_o(empty_o)
  );

  assign status_o       = rq_dout.status;
  assign slot_o         = rq_dout.slot;
  assign ticker_code_o  = rq_dout.code;
  assign total_value_o  = rq_dout.value;
  assign total_volume_o = rq_dout.volume;

endmodule
